// File: hdl/paired_read_reorder_index_unit_macros.svh
// ----------------------------------------------------------------------------
// paired read reorder index unit assertion macros
// concurrent assertion shorthands shared by the unit's checks
// ----------------------------------------------------------------------------
`ifndef PAIRED_READ_REORDER_INDEX_UNIT_MACROS_SVH
`define PAIRED_READ_REORDER_INDEX_UNIT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define PRRI_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("prri assertion failed");

// consequent checked in the cycle after the antecedent
`define PRRI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("prri assertion failed");

`endif

// File: hdl/prri_pkg.sv
// ----------------------------------------------------------------------------
// prri_pkg
// types, codes and widths shared by the paired read reorder index unit
// ----------------------------------------------------------------------------
package prri_pkg;

	localparam int CNT_W  = 11;
	localparam int READ_W = 10;
	localparam int KIND_W = 2;
	localparam int STAT_W = 2;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_LOAD     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SCAN     = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READBACK = 2'd2;

	// result status codes
	localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_MATE  = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd2;

	// register word index
	localparam logic REG_READ_COUNT = 1'b0;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [READ_W-1:0] value;
		logic [READ_W-1:0] index;
	} item_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic              single_valid;
		logic [READ_W-1:0] single_read;
		logic [READ_W-1:0] new_position;
	} result_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_SCAN_CUR,
		ST_SCAN_MATE,
		ST_SCAN_WR2,
		ST_RB_DATA,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic              capture;
		logic              do_load;
		logic              scan_adv;
		logic              mark;
		logic              place_first;
		logic              place_second;
		logic              take_np;
		logic              set_status;
		logic [STAT_W-1:0] status;
		logic              emit;
		logic              clr_write;
	} cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              load_bad;
		logic              scan_end;
		logic              rb_bad;
		logic              cur_bad;
		logic              mate_seen;
		logic              mpos_before;
		logic              mpos_bad;
		logic              clr_last;
		logic              out_free;
	} sts_t;

endpackage

// File: hdl/prri_ram.sv
// ----------------------------------------------------------------------------
// prri_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module prri_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hdl/prri_ctrl.sv
// ----------------------------------------------------------------------------
// prri_ctrl
// sequencer for load, scan and read-back items and the seen map clear sweep
// ----------------------------------------------------------------------------
module prri_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  prri_pkg::sts_t sts,
	output prri_pkg::cmd_t cmd
);

	prri_pkg::state_t state_q;
	prri_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prri_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign item_stall = (state_q != prri_pkg::ST_IDLE);

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.status = prri_pkg::STATUS_OK;
		case (state_q)
			prri_pkg::ST_CLEAR: begin
				cmd.clr_write = 1'b1;
				if (sts.clr_last) begin
					state_d = prri_pkg::ST_IDLE;
				end
			end
			prri_pkg::ST_IDLE: begin
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d     = prri_pkg::ST_DECODE;
				end
			end
			prri_pkg::ST_DECODE: begin
				state_d = prri_pkg::ST_EMIT;
				case (sts.kind)
					prri_pkg::KIND_LOAD: begin
						if (sts.load_bad) begin
							cmd.set_status = 1'b1;
							cmd.status     = prri_pkg::STATUS_RANGE;
						end else begin
							cmd.do_load = 1'b1;
						end
					end
					prri_pkg::KIND_SCAN: begin
						if (sts.scan_end) begin
							cmd.set_status = 1'b1;
							cmd.status     = prri_pkg::STATUS_RANGE;
						end else begin
							state_d = prri_pkg::ST_SCAN_CUR;
						end
					end
					prri_pkg::KIND_READBACK: begin
						if (sts.rb_bad) begin
							cmd.set_status = 1'b1;
							cmd.status     = prri_pkg::STATUS_RANGE;
						end else begin
							state_d = prri_pkg::ST_RB_DATA;
						end
					end
					default: begin
						cmd.set_status = 1'b1;
						cmd.status     = prri_pkg::STATUS_RANGE;
					end
				endcase
			end
			prri_pkg::ST_SCAN_CUR: begin
				cmd.scan_adv = 1'b1;
				if (sts.cur_bad) begin
					cmd.set_status = 1'b1;
					cmd.status     = prri_pkg::STATUS_RANGE;
					state_d        = prri_pkg::ST_EMIT;
				end else begin
					cmd.mark = 1'b1;
					state_d  = prri_pkg::ST_SCAN_MATE;
				end
			end
			prri_pkg::ST_SCAN_MATE: begin
				state_d = prri_pkg::ST_EMIT;
				if (!sts.mate_seen) begin
					if (sts.mpos_before) begin
						cmd.set_status = 1'b1;
						cmd.status     = prri_pkg::STATUS_MATE;
					end else if (sts.mpos_bad) begin
						cmd.set_status = 1'b1;
						cmd.status     = prri_pkg::STATUS_RANGE;
					end else begin
						cmd.place_first = 1'b1;
						state_d         = prri_pkg::ST_SCAN_WR2;
					end
				end
			end
			prri_pkg::ST_SCAN_WR2: begin
				cmd.place_second = 1'b1;
				state_d          = prri_pkg::ST_EMIT;
			end
			prri_pkg::ST_RB_DATA: begin
				cmd.take_np = 1'b1;
				state_d     = prri_pkg::ST_EMIT;
			end
			prri_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = prri_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = prri_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// File: hdl/prri_dpath.sv
// ----------------------------------------------------------------------------
// prri_dpath
// stores, counters, range checks and result register of the reorder unit
// ----------------------------------------------------------------------------
module prri_dpath #(
	parameter int MAX_READS = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  prri_pkg::item_t              item,
	input  logic [prri_pkg::CNT_W-1:0]   read_count,
	input  prri_pkg::cmd_t               cmd,
	output prri_pkg::sts_t               sts,
	output logic                         result_valid,
	input  logic                         result_stall,
	output prri_pkg::result_t            result
);

	localparam int AW      = $clog2(MAX_READS);
	localparam int CW      = prri_pkg::CNT_W;
	localparam int RW      = prri_pkg::READ_W;
	localparam int CAP_I   = MAX_READS - (MAX_READS % 2);
	localparam int CNT_TOP = (1 << CW) - 2;
	localparam logic [CW-1:0] CAP = (CAP_I > CNT_TOP) ? CW'(CNT_TOP) : CW'(CAP_I);
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_READS - 1);

	prri_pkg::item_t   item_q;
	prri_pkg::result_t res_q;
	prri_pkg::result_t out_q;
	logic              out_valid_q;

	logic [CW-1:0] load_cnt_q;
	logic [CW-1:0] scan_cnt_q;
	logic [RW-1:0] next_slot_q;
	logic [AW-1:0] clr_cnt_q;
	logic [CW-1:0] pos_q;
	logic [RW-1:0] cur_q;
	logic [CW-1:0] mate_q;
	logic          cur_low_q;
	logic [CW-1:0] mpos_q;

	logic [CW-1:0] rc_even;
	logic [CW-1:0] n;
	logic [CW-1:0] half;
	logic [RW-1:0] order_rd;
	logic [CW-1:0] inv_rd;
	logic          seen_rd;
	logic [RW-1:0] new_rd;
	logic [CW-1:0] cur_ext;
	logic          cur_low;
	logic [CW-1:0] mate_d;
	logic [RW-1:0] slot_lo;
	logic [RW-1:0] slot_hi;
	logic [RW-1:0] slot_pos;
	logic [RW-1:0] slot_mate;
	logic [RW-1:0] lo_read;

	// effective count: even, capped at the store depth
	assign rc_even = {read_count[CW-1:1], 1'b0};
	assign n       = (rc_even > CAP) ? CAP : rc_even;
	assign half    = {1'b0, n[CW-1:1]};

	assign cur_ext = CW'(order_rd);
	assign cur_low = (cur_ext < half);
	assign mate_d  = cur_low ? (cur_ext + half) : (cur_ext - half);

	assign slot_lo   = next_slot_q;
	assign slot_hi   = next_slot_q + half[RW-1:0];
	assign slot_pos  = cur_low_q ? slot_lo : slot_hi;
	assign slot_mate = cur_low_q ? slot_hi : slot_lo;
	assign lo_read   = cur_low_q ? cur_q : mate_q[RW-1:0];

	prri_ram #(.WIDTH(RW), .DEPTH(MAX_READS)) u_order_ram (
		.clk   (clk),
		.we    (cmd.do_load),
		.waddr (AW'(load_cnt_q)),
		.wdata (item_q.value),
		.raddr (AW'(scan_cnt_q)),
		.rdata (order_rd)
	);

	prri_ram #(.WIDTH(CW), .DEPTH(MAX_READS)) u_inverse_ram (
		.clk   (clk),
		.we    (cmd.do_load),
		.waddr (AW'(item_q.value)),
		.wdata (load_cnt_q),
		.raddr (AW'(mate_d)),
		.rdata (inv_rd)
	);

	prri_ram #(.WIDTH(1), .DEPTH(MAX_READS)) u_seen_ram (
		.clk   (clk),
		.we    (cmd.clr_write | cmd.mark),
		.waddr (cmd.clr_write ? clr_cnt_q : AW'(cur_ext)),
		.wdata (cmd.mark),
		.raddr (AW'(mate_d)),
		.rdata (seen_rd)
	);

	prri_ram #(.WIDTH(RW), .DEPTH(MAX_READS)) u_new_order_ram (
		.clk   (clk),
		.we    (cmd.place_first | cmd.place_second),
		.waddr (cmd.place_first ? AW'(pos_q) : AW'(mpos_q)),
		.wdata (cmd.place_first ? slot_pos : slot_mate),
		.raddr (AW'(item_q.index)),
		.rdata (new_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q  <= '0;
			scan_cnt_q  <= '0;
			next_slot_q <= '0;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.do_load) begin
				load_cnt_q <= load_cnt_q + 1'b1;
			end
			if (cmd.scan_adv) begin
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end
			if (cmd.place_second) begin
				next_slot_q <= next_slot_q + 1'b1;
			end
			if (cmd.clr_write) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
			res_q  <= '0;
		end
		if (cmd.set_status) begin
			res_q.status <= cmd.status;
		end
		if (cmd.scan_adv) begin
			pos_q <= scan_cnt_q;
		end
		if (cmd.mark) begin
			cur_q     <= order_rd;
			mate_q    <= mate_d;
			cur_low_q <= cur_low;
		end
		if (cmd.place_first) begin
			mpos_q             <= inv_rd;
			res_q.single_valid <= 1'b1;
			res_q.single_read  <= lo_read;
		end
		if (cmd.take_np) begin
			res_q.new_position <= new_rd;
		end
		if (cmd.emit) begin
			out_q <= res_q;
		end
	end

	always_comb begin
		sts             = '0;
		sts.kind        = item_q.kind;
		sts.load_bad    = (load_cnt_q >= n) || (CW'(item_q.value) >= n);
		sts.scan_end    = (scan_cnt_q >= n);
		sts.rb_bad      = (CW'(item_q.index) >= n);
		sts.cur_bad     = (cur_ext >= n);
		sts.mate_seen   = seen_rd;
		sts.mpos_before = (inv_rd < pos_q);
		sts.mpos_bad    = (inv_rd >= n);
		sts.clr_last    = (clr_cnt_q == LAST_ADDR);
		sts.out_free    = !out_valid_q || !result_stall;
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

// File: hdl/paired_read_reorder_index_unit.sv
// ----------------------------------------------------------------------------
// paired_read_reorder_index_unit
// builds a mate-preserving read order from a loaded permutation of reads
// ----------------------------------------------------------------------------
//  port group    direction  handshake                        payload
//  apb config    in         psel/penable/pwrite, pready=1    read_count at word 0
//  item          in         item_valid / item_stall          prri_pkg::item_t
//  result        out        result_valid / result_stall      prri_pkg::result_t
//
//  one item at a time: load and out-of-range items go through decode and emit,
//  read-back adds a new order read, scan adds an order read, a seen and inverse
//  read, then two writes into the new order ram, which has one write port
//  after reset the seen map is cleared one entry at a time, item_stall high
//  a stalled result holds in the output register; the sequencer waits on it
//  only when a second result is ready
// ----------------------------------------------------------------------------
`include "paired_read_reorder_index_unit_macros.svh"

module paired_read_reorder_index_unit #(
	parameter int MAX_READS = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [prri_pkg::APB_AW-1:0]   paddr,
	input  logic [prri_pkg::APB_DW-1:0]   pwdata,
	output logic [prri_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  prri_pkg::item_t               item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output prri_pkg::result_t             result
);

	logic [prri_pkg::CNT_W-1:0] read_count_q;
	logic                       reg_sel;
	prri_pkg::cmd_t             cmd;
	prri_pkg::sts_t             sts;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[prri_pkg::APB_AW-1] == prri_pkg::REG_READ_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_count_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			read_count_q <= pwdata[prri_pkg::CNT_W-1:0];
		end
	end

	assign prdata = reg_sel ? prri_pkg::APB_DW'(read_count_q) : '0;

	prri_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	prri_dpath #(.MAX_READS(MAX_READS)) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.read_count   (read_count_q),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	`PRRI_ASSERT_NEXT(a_one_item_in_flight, clk, arst_n, item_valid && !item_stall, item_stall)
	`PRRI_ASSERT_SAME(a_emit_into_free_reg, clk, arst_n, cmd.emit, !(result_valid && result_stall))
	`PRRI_ASSERT_SAME(a_single_word_ok, clk, arst_n, result_valid && result.single_valid, result.status == prri_pkg::STATUS_OK)

endmodule

// File: dv/prri_tb_pkg.sv
// ----------------------------------------------------------------------------
// prri_tb_pkg
// scoreboard for the paired read reorder index unit: tracks the loaded
// permutation, the seen map and the new order, and checks each result beat
// ----------------------------------------------------------------------------
package prri_tb_pkg;
	import prri_pkg::*;

	localparam int READS = 1024;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	class mate_order_scoreboard;
		logic [CNT_W-1:0]  read_count;
		logic [READ_W-1:0] order_mem [READS];
		logic [READ_W-1:0] inverse_mem [READS];
		logic [READ_W-1:0] new_order_mem [READS];
		bit                order_wr [READS];
		bit                inverse_wr [READS];
		bit                new_order_wr [READS];
		bit                seen [READS];
		int unsigned       loads_done;
		int unsigned       scans_done;
		logic [READ_W-1:0] slot_next;
		int                placed_positions [$];
		result_t           awaited_results [$];
		int                mismatches;
		int                results_taken;

		function new();
			read_count = '0;
			loads_done = 0;
			scans_done = 0;
			slot_next = '0;
			mismatches = 0;
			results_taken = 0;
		endfunction

		function void set_read_count(logic [CNT_W-1:0] cnt);
			read_count = cnt;
		endfunction

		// even part of the count, capped at the store depth
		function int unsigned batch_size();
			int unsigned n;
			n = int'({read_count[CNT_W-1:1], 1'b0});
			return (n < READS) ? n : READS;
		endfunction

		// true when the item would read a store entry that was never written
		function bit reads_unwritten(item_t it);
			int unsigned n, half, pos, cur, mate;
			n = batch_size();
			half = n / 2;
			if (it.kind == KIND_READBACK)
				return it.index < n && !new_order_wr[it.index];
			if (it.kind != KIND_SCAN || scans_done >= n)
				return 1'b0;
			pos = scans_done;
			if (!order_wr[pos])
				return 1'b1;
			cur = order_mem[pos];
			if (cur >= n)
				return 1'b0;
			mate = (cur >= half) ? cur - half : cur + half;
			return !seen[mate] && !inverse_wr[mate];
		endfunction

		function void mark_placed(int unsigned pos);
			if (!new_order_wr[pos])
				placed_positions.push_back(pos);
			new_order_wr[pos] = 1'b1;
		endfunction

		function result_t mate_order_step(item_t it);
			result_t     r;
			int unsigned n, half, pos, cur, mate, mpos;
			logic [READ_W-1:0] half_w;
			n = batch_size();
			half = n / 2;
			half_w = READ_W'(half);
			r = '0;
			r.status = STATUS_OK;
			case (it.kind)
				KIND_LOAD: begin
					if (loads_done >= n || it.value >= n) begin
						r.status = STATUS_RANGE;
					end else begin
						order_mem[loads_done] = it.value;
						order_wr[loads_done] = 1'b1;
						inverse_mem[it.value] = READ_W'(loads_done);
						inverse_wr[it.value] = 1'b1;
						loads_done++;
					end
				end
				KIND_SCAN: begin
					if (scans_done >= n) begin
						r.status = STATUS_RANGE;
					end else begin
						pos = scans_done;
						cur = order_mem[pos];
						scans_done++;
						if (cur >= n) begin
							r.status = STATUS_RANGE;
						end else begin
							mate = (cur >= half) ? cur - half : cur + half;
							seen[cur] = 1'b1;
							if (!seen[mate]) begin
								mpos = inverse_mem[mate];
								if (mpos < pos) begin
									r.status = STATUS_MATE;
								end else if (mpos >= n) begin
									r.status = STATUS_RANGE;
								end else begin
									// lower read index takes the slot, its mate the slot plus half
									new_order_mem[pos] = (cur < mate) ? slot_next : slot_next + half_w;
									new_order_mem[mpos] = (cur < mate) ? slot_next + half_w : slot_next;
									mark_placed(pos);
									mark_placed(mpos);
									slot_next++;
									r.single_valid = 1'b1;
									r.single_read = READ_W'((cur < mate) ? cur : mate);
								end
							end
						end
					end
				end
				KIND_READBACK: begin
					if (it.index >= n)
						r.status = STATUS_RANGE;
					else
						r.new_position = new_order_mem[it.index];
				end
				default: begin
					r.status = STATUS_RANGE;
				end
			endcase
			return r;
		endfunction

		function void note_item(item_t it);
			awaited_results.push_back(mate_order_step(it));
		endfunction

		function void check_result(result_t got);
			result_t want;
			results_taken++;
			if (awaited_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result beat %0d arrived with nothing awaited: status %0d valid %0d read %0d pos %0d",
						results_taken, got.status, got.single_valid, got.single_read, got.new_position);
				return;
			end
			want = awaited_results.pop_front();
			if (got.status !== want.status || got.single_valid !== want.single_valid ||
					got.single_read !== want.single_read || got.new_position !== want.new_position) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result beat %0d mismatch: expected status %0d valid %0d read %0d pos %0d, got status %0d valid %0d read %0d pos %0d",
						results_taken, want.status, want.single_valid, want.single_read,
						want.new_position, got.status, got.single_valid, got.single_read,
						got.new_position);
			end
		endfunction
	endclass

endpackage

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// drives load, scan and read-back beats into the paired read reorder index
// unit under several read counts and idle patterns, and checks every result
// beat against a scoreboard that tracks the mate-preserving order
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import prri_pkg::*;
	import prri_tb_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam int HOLD_AT     = 720;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic              item_valid;
	logic              item_stall;
	item_t             item;
	logic              result_valid;
	logic              result_stall;
	result_t           result;

	mate_order_scoreboard sb = new();

	int send_idle_pct;
	int recv_idle_pct;
	int reads_fresh [$];
	int quiet_cycles = 0;
	bit held_off = 1'b0;

	paired_read_reorder_index_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result(result);
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) || (psel && penable))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", quiet_cycles);
			$display("** paired_read_reorder_index_unit: FAILED **");
			$finish;
		end
	end

	// receiver: random stall, plus one long hold so the unit backs up
	initial begin
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!held_off && sb.results_taken >= HOLD_AT) begin
				held_off = 1'b1;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	function automatic item_t mk_item(logic [KIND_W-1:0] kind, logic [READ_W-1:0] value,
			logic [READ_W-1:0] index);
		item_t it;
		it.kind = kind;
		it.value = value;
		it.index = index;
		return it;
	endfunction

	task automatic offer_item(input item_t it);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		sb.note_item(it);
		@(negedge clk);
	endtask

	// register writes only once every result beat is back
	task automatic write_read_count(input logic [CNT_W-1:0] cnt);
		item_valid <= 1'b0;
		while (sb.awaited_results.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_READ_COUNT, 2'b00};
		pwdata <= APB_DW'(cnt);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.set_read_count(cnt);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic item_t next_stimulus();
		item_t       it;
		int unsigned n, half, pos, cur, mate, roll;
		bit          from_pool;
		n = sb.batch_size();
		half = n / 2;
		from_pool = 1'b0;
		it.kind = KIND_LOAD;
		it.value = READ_W'($urandom);
		it.index = READ_W'($urandom);
		roll = $urandom_range(0, 99);
		if (roll < 3) begin
			it.kind = KIND_UNUSED;
		end else if (roll < 15) begin
			it.kind = KIND_READBACK;
			if (sb.placed_positions.size() != 0 && roll < 12)
				it.index = READ_W'(sb.placed_positions[$urandom_range(0,
					sb.placed_positions.size() - 1)]);
		end else if (roll < 57) begin
			it.kind = KIND_SCAN;
			pos = sb.scans_done;
			if (pos < n && !sb.order_wr[pos]) begin
				// position not loaded yet: load it instead
				it.kind = KIND_LOAD;
				from_pool = 1'b1;
			end else if (pos < n) begin
				cur = sb.order_mem[pos];
				if (cur < n) begin
					mate = (cur >= half) ? cur - half : cur + half;
					if (!sb.seen[mate] && !sb.inverse_wr[mate]) begin
						// mate never loaded: load it, if loads remain, so the scan can go on
						it.kind = (sb.loads_done < n) ? KIND_LOAD : KIND_READBACK;
						it.value = READ_W'(mate);
						for (int j = 0; j < reads_fresh.size(); j++) begin
							if (reads_fresh[j] == mate) begin
								reads_fresh.delete(j);
								break;
							end
						end
					end
				end
			end
		end else begin
			from_pool = 1'b1;
		end
		if (from_pool) begin
			if (reads_fresh.size() != 0 && $urandom_range(0, 99) < 88)
				it.value = READ_W'(reads_fresh.pop_front());
			else if (n != 0 && $urandom_range(0, 1) == 1)
				it.value = READ_W'($urandom_range(0, n - 1));
		end
		if (sb.reads_unwritten(it))
			it.kind = KIND_UNUSED;
		return it;
	endfunction

	task automatic run_random_phase(input logic [CNT_W-1:0] cnt, input int count);
		int unsigned n;
		int          j, tmp;
		write_read_count(cnt);
		reads_fresh.delete();
		n = sb.batch_size();
		for (int v = 0; v < n; v++)
			if (!sb.inverse_wr[v])
				reads_fresh.push_back(v);
		for (int i = reads_fresh.size() - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = reads_fresh[i];
			reads_fresh[i] = reads_fresh[j];
			reads_fresh[j] = tmp;
		end
		repeat (count) offer_item(next_stimulus());
	endtask

	initial begin
		int perm [8];
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_valid = 1'b0;
		item = '0;
		send_idle_pct = 33;
		recv_idle_pct = 52;
		perm = '{6, 0, 3, 1, 2, 5, 4, 7};
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty batch: everything is out of range
		offer_item(mk_item(KIND_LOAD, '0, '0));
		offer_item(mk_item(KIND_SCAN, '1, '0));
		offer_item(mk_item(KIND_READBACK, '0, '0));
		offer_item(mk_item(KIND_UNUSED, '1, '1));

		write_read_count(11'd8);
		offer_item(mk_item(KIND_LOAD, '1, '0));
		foreach (perm[i])
			offer_item(mk_item(KIND_LOAD, READ_W'(perm[i]), '0));
		offer_item(mk_item(KIND_LOAD, '0, '0));

		// shrink to four: stored read out of range, mate position out of range,
		// a pair placed higher read first, a mate already seen, scan past end
		write_read_count(11'd4);
		repeat (5) offer_item(mk_item(KIND_SCAN, '0, '0));
		offer_item(mk_item(KIND_READBACK, '0, 10'd2));
		offer_item(mk_item(KIND_READBACK, '0, 10'd3));
		offer_item(mk_item(KIND_READBACK, '0, 10'd4));
		offer_item(mk_item(KIND_READBACK, '0, '1));

		// back to eight: the mate of read 2 sits unseen at position 0
		write_read_count(11'd8);
		offer_item(mk_item(KIND_SCAN, '0, '0));

		run_random_phase(11'd64, 150);
		run_random_phase(11'd200, 170);
		send_idle_pct = 52;
		recv_idle_pct = 33;
		run_random_phase(11'd97, 120);
		run_random_phase(11'd1024, 200);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random_phase(11'd0, 30);
		run_random_phase(11'd1023, 200);
		run_random_phase(11'd1024, 100);

		item_valid <= 1'b0;
		while (sb.awaited_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0 && sb.awaited_results.size() == 0)
			$display("** paired_read_reorder_index_unit: PASSED **");
		else
			$display("** paired_read_reorder_index_unit: FAILED **");
		$finish;
	end

endmodule
